// ===== design/ota_session_arbiter_unit_assert.svh =====
// Assertion macros shared by the session arbiter modules
`ifndef OTA_SESSION_ARBITER_UNIT_ASSERT_SVH
`define OTA_SESSION_ARBITER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Implication in the same cycle
`define OTASA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle
`define OTASA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define OTASA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OTASA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/otasa_pkg.sv =====
package otasa_pkg;

  // Special addresses and program area bounds
  localparam logic [15:0] NO_NODE     = 16'hFFFF;
  localparam logic [15:0] BROADCAST   = 16'hFFFF;
  localparam logic [15:0] PRGM_START  = 16'h0400;
  localparam logic [15:0] PRGM_END    = 16'h6400 - 16'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_HW_TYPE  = 8'd0;
  localparam logic [7:0]  RST_VERSION  = 8'd1;
  localparam logic [15:0] RST_END_ADDR = 16'd25598;
  localparam logic [7:0]  RST_EXPIRE   = 8'd10;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HW_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_ADDR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRE   = 2'd3;

  // Request opcodes
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_DATA    = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_TRIGGER = 3'd4;

  // Reply kinds
  localparam logic [2:0] K_NONE    = 3'd0;
  localparam logic [2:0] K_ACTIVE  = 3'd1;
  localparam logic [2:0] K_PASSIVE = 3'd2;
  localparam logic [2:0] K_DATA    = 3'd3;
  localparam logic [2:0] K_TRIGGER = 3'd4;
  localparam logic [2:0] K_TIMEOUT = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] src_address;
    logic [7:0]  req_hw_type;
    logic [7:0]  req_version;
    logic [15:0] req_data_address;
    logic        send_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  reply_kind;
    logic [15:0] dest_address;
    logic [7:0]  reply_version;
    logic [15:0] reply_address;
    logic        session_done;
  } rsp_t;

  // Configuration write as seen by the session core
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ===== design/otasa_if.sv =====
// Request channel
interface otasa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] src_address;
  logic [7:0]  req_hw_type;
  logic [7:0]  req_version;
  logic [15:0] req_data_address;
  logic        send_ok;

  modport source (output valid, output opcode, output src_address, output req_hw_type,
                  output req_version, output req_data_address, output send_ok,
                  input ready);
  modport sink (input valid, input opcode, input src_address, input req_hw_type,
                input req_version, input req_data_address, input send_ok,
                output ready);
endinterface

// Reply channel
interface otasa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reply_kind;
  logic [15:0] dest_address;
  logic [7:0]  reply_version;
  logic [15:0] reply_address;
  logic        session_done;

  modport source (output valid, output reply_kind, output dest_address,
                  output reply_version, output reply_address, output session_done,
                  input ready);
  modport sink (input valid, input reply_kind, input dest_address,
                input reply_version, input reply_address, input session_done,
                output ready);
endinterface

// ===== design/otasa_core.sv =====
`include "ota_session_arbiter_unit_assert.svh"

// Configuration registers, session state and reply decode
module otasa_core
  import otasa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  logic    accept,
  input  req_t    req,
  output rsp_t    rsp
);

  logic [7:0]  hw_type_r;
  logic [7:0]  version_r;
  logic [15:0] end_addr_r;
  logic [7:0]  expire_r;

  logic [15:0] active_node_r, active_node_nxt;
  logic        running_r, running_nxt;
  logic [7:0]  countdown_r, countdown_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_type_r  <= RST_HW_TYPE;
      version_r  <= RST_VERSION;
      end_addr_r <= RST_END_ADDR;
      expire_r   <= RST_EXPIRE;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_HW_TYPE:  hw_type_r  <= cfg.data[7:0];
        REG_VERSION:  version_r  <= cfg.data[7:0];
        REG_END_ADDR: end_addr_r <= cfg.data;
        REG_EXPIRE:   expire_r   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Reply and next session state for the current request
  always_comb begin
    active_node_nxt = active_node_r;
    running_nxt     = running_r;
    countdown_nxt   = countdown_r;
    rsp             = '0;
    case (req.opcode)
      OP_START: begin
        if (req.src_address != 16'd0 && req.req_hw_type == hw_type_r) begin
          rsp.reply_kind    = (active_node_r == NO_NODE || active_node_r == req.src_address)
                              ? K_ACTIVE : K_PASSIVE;
          rsp.dest_address  = req.src_address;
          rsp.reply_version = version_r;
          rsp.reply_address = end_addr_r;
          // successful send to a free session claims it
          if (active_node_r == NO_NODE && req.send_ok) begin
            active_node_nxt = req.src_address;
            if (!running_r) begin
              running_nxt   = 1'b1;
              countdown_nxt = expire_r;
            end
          end
        end
      end
      OP_DATA: begin
        if (req.src_address != 16'd0 &&
            req.req_data_address inside {[PRGM_START:PRGM_END]} &&
            active_node_r != NO_NODE && active_node_r == req.src_address &&
            req.req_hw_type == hw_type_r && req.req_version == version_r) begin
          rsp.reply_kind    = K_DATA;
          rsp.dest_address  = BROADCAST;
          rsp.reply_version = version_r;
          rsp.reply_address = req.req_data_address;
          countdown_nxt     = expire_r;
          // last block closes the session
          if (req.req_data_address >= end_addr_r) begin
            active_node_nxt  = NO_NODE;
            running_nxt      = 1'b0;
            rsp.session_done = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (running_r) begin
          if (countdown_r <= 8'd1) begin
            rsp.reply_kind   = K_TIMEOUT;
            rsp.dest_address = active_node_r;
            active_node_nxt  = NO_NODE;
            running_nxt      = 1'b0;
            countdown_nxt    = expire_r;
          end else begin
            countdown_nxt = countdown_r - 8'd1;
          end
        end
      end
      OP_CLEAR: begin
        active_node_nxt = NO_NODE;
      end
      OP_TRIGGER: begin
        rsp.reply_kind   = K_TRIGGER;
        rsp.dest_address = BROADCAST;
      end
      default: ;
    endcase
  end

  // Session state advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_node_r <= NO_NODE;
      running_r     <= 1'b0;
      countdown_r   <= RST_EXPIRE;
    end else if (accept) begin
      active_node_r <= active_node_nxt;
      running_r     <= running_nxt;
      countdown_r   <= countdown_nxt;
    end
  end

  `OTASA_ASSERT_NEXT(a_timeout_frees, clk, rst_n, accept && rsp.reply_kind == K_TIMEOUT, active_node_r == NO_NODE && !running_r)
  `OTASA_ASSERT_NEXT(a_done_frees, clk, rst_n, accept && rsp.session_done, active_node_r == NO_NODE)
  `OTASA_ASSERT_NOW(a_data_needs_owner, clk, rst_n, rsp.reply_kind == K_DATA, active_node_r == req.src_address && active_node_r != NO_NODE)

endmodule

// ===== design/ota_session_arbiter_unit.sv =====
// Over-the-air update session arbiter. Every accepted request transaction
// yields exactly one reply transaction, registered, in the cycle after
// acceptance; kind 0 means no frame is to be sent. One request is taken per
// clock: in_ch.ready is high whenever the single output register is empty or
// its reply is being taken in the same cycle, so throughput is one request
// per cycle while replies are drained, limited only by that output register.
// Configuration registers (0 hw type, 1 version, 2 end address, 3 expire
// ticks) are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while no transaction is in flight; the block does not enforce it.
`include "ota_session_arbiter_unit_assert.svh"

module ota_session_arbiter_unit
  import otasa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  otasa_req_if.sink             in_ch,
  otasa_rsp_if.source           out_ch
);

  req_t    req;
  rsp_t    rsp;
  rsp_t    rsp_r;
  cfg_wr_t cfg;
  logic    out_valid_r;
  logic    accept;

  assign req = '{opcode:           in_ch.opcode,
                 src_address:      in_ch.src_address,
                 req_hw_type:      in_ch.req_hw_type,
                 req_version:      in_ch.req_version,
                 req_data_address: in_ch.req_data_address,
                 send_ok:          in_ch.send_ok};
  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

  // Accept while the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  otasa_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (accept),
    .req    (req),
    .rsp    (rsp)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.reply_kind    = rsp_r.reply_kind;
  assign out_ch.dest_address  = rsp_r.dest_address;
  assign out_ch.reply_version = rsp_r.reply_version;
  assign out_ch.reply_address = rsp_r.reply_address;
  assign out_ch.session_done  = rsp_r.session_done;

  `OTASA_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, out_valid_r)
  `OTASA_ASSERT_NOW(a_stall_blocks, clk, rst_n, out_valid_r && !out_ch.ready, !in_ch.ready)
  `OTASA_ASSERT_NOW(a_none_is_zero, clk, rst_n, out_valid_r && rsp_r.reply_kind == K_NONE, rsp_r.dest_address == 16'd0 && rsp_r.reply_address == 16'd0 && rsp_r.reply_version == 8'd0 && !rsp_r.session_done)
  `OTASA_ASSERT_NOW(a_done_is_data, clk, rst_n, out_valid_r && rsp_r.session_done, rsp_r.reply_kind == K_DATA)

endmodule

// ===== verif/ota_session_arbiter_unit_test.sv =====
`timescale 1ns / 100ps

module ota_session_arbiter_unit_test;
  import otasa_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  otasa_req_if in_ch();
  otasa_rsp_if out_ch();

  ota_session_arbiter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Request transactions waiting to be sent, replies waiting to arrive
  req_t request_q[$];
  rsp_t expected_replies[$];
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  // Shadow of the server configuration and session state
  logic [7:0]  cur_hw_type;
  logic [7:0]  cur_version;
  logic [15:0] cur_end_addr;
  logic [7:0]  cur_expire;
  logic [15:0] owner_node;
  logic        timer_armed;
  logic [7:0]  timer_left;

  // Stimulus-side view of the session being driven
  logic [15:0] sess_node = 16'h1234;
  int          sess_addr = 32'h400;

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Session server behavior: one reply per request, state updated in place
  function automatic rsp_t serve_request(input req_t rq);
    rsp_t rs;
    rs = '0;
    case (rq.opcode)
      OP_START: begin
        if (rq.src_address != 16'd0 && rq.req_hw_type == cur_hw_type) begin
          rs.reply_kind = (owner_node == NO_NODE || owner_node == rq.src_address) ?
                          K_ACTIVE : K_PASSIVE;
          rs.dest_address  = rq.src_address;
          rs.reply_version = cur_version;
          rs.reply_address = cur_end_addr;
          // claim only on a free session and a good send
          if (owner_node == NO_NODE && rq.send_ok) begin
            owner_node = rq.src_address;
            if (!timer_armed) begin
              timer_armed = 1'b1;
              timer_left  = cur_expire;
            end
          end
        end
      end
      OP_DATA: begin
        if (rq.src_address != 16'd0 && rq.req_data_address >= PRGM_START &&
            rq.req_data_address <= PRGM_END && owner_node != NO_NODE &&
            owner_node == rq.src_address && rq.req_hw_type == cur_hw_type &&
            rq.req_version == cur_version) begin
          rs.reply_kind    = K_DATA;
          rs.dest_address  = BROADCAST;
          rs.reply_version = cur_version;
          rs.reply_address = rq.req_data_address;
          timer_left = cur_expire;
          // last block closes the session
          if (rq.req_data_address >= cur_end_addr) begin
            owner_node = NO_NODE;
            if (timer_armed) begin
              timer_armed = 1'b0;
              timer_left  = cur_expire;
            end
            rs.session_done = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (timer_armed) begin
          if (timer_left <= 8'd1) begin
            rs.reply_kind   = K_TIMEOUT;
            rs.dest_address = owner_node;
            owner_node  = NO_NODE;
            timer_armed = 1'b0;
            timer_left  = cur_expire;
          end else begin
            timer_left = timer_left - 8'd1;
          end
        end
      end
      OP_CLEAR: owner_node = NO_NODE;
      OP_TRIGGER: begin
        rs.reply_kind   = K_TRIGGER;
        rs.dest_address = BROADCAST;
      end
      default: ;
    endcase
    return rs;
  endfunction

  // Driver: next request goes out once the current one is taken
  always @(posedge clk) begin
    req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        in_ch.opcode           <= nxt.opcode;
        in_ch.src_address      <= nxt.src_address;
        in_ch.req_hw_type      <= nxt.req_hw_type;
        in_ch.req_version      <= nxt.req_version;
        in_ch.req_data_address <= nxt.req_data_address;
        in_ch.send_ok          <= nxt.send_ok;
        in_ch.valid            <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Reply side backpressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: check replies against the oldest expectation, then predict
  always @(posedge clk) begin
    rsp_t want;
    req_t taken;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          flag_mismatch("reply with none pending, kind", 16'(out_ch.reply_kind), 16'd0);
        end else begin
          want = expected_replies.pop_front();
          if (out_ch.reply_kind !== want.reply_kind)
            flag_mismatch("reply_kind", 16'(out_ch.reply_kind), 16'(want.reply_kind));
          if (out_ch.dest_address !== want.dest_address)
            flag_mismatch("dest_address", out_ch.dest_address, want.dest_address);
          if (out_ch.reply_version !== want.reply_version)
            flag_mismatch("reply_version", 16'(out_ch.reply_version),
                          16'(want.reply_version));
          if (out_ch.reply_address !== want.reply_address)
            flag_mismatch("reply_address", out_ch.reply_address, want.reply_address);
          if (out_ch.session_done !== want.session_done)
            flag_mismatch("session_done", 16'(out_ch.session_done),
                          16'(want.session_done));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.opcode           = in_ch.opcode;
        taken.src_address      = in_ch.src_address;
        taken.req_hw_type      = in_ch.req_hw_type;
        taken.req_version      = in_ch.req_version;
        taken.req_data_address = in_ch.req_data_address;
        taken.send_ok          = in_ch.send_ok;
        expected_replies.push_back(serve_request(taken));
      end
    end
  end

  task automatic add_item(input logic [2:0] op, input logic [15:0] src,
                          input logic [7:0] hw, input logic [7:0] ver,
                          input logic [15:0] addr, input logic ok);
    req_t rq;
    rq.opcode           = op;
    rq.src_address      = src;
    rq.req_hw_type      = hw;
    rq.req_version      = ver;
    rq.req_data_address = addr;
    rq.send_ok          = ok;
    request_q.push_back(rq);
  endtask

  // Register write; 8-bit registers get junk in the upper byte
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_HW_TYPE:  cur_hw_type  = val[7:0];
      REG_VERSION:  cur_version  = val[7:0];
      REG_END_ADDR: cur_end_addr = val;
      REG_EXPIRE:   cur_expire   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [7:0] hw, input logic [7:0] ver,
                             input logic [15:0] end_addr, input logic [7:0] expire);
    write_reg(REG_HW_TYPE, {8'($urandom), hw});
    write_reg(REG_VERSION, {8'($urandom), ver});
    write_reg(REG_END_ADDR, end_addr);
    write_reg(REG_EXPIRE, {8'($urandom), expire});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Corner cases of the session protocol
  task automatic add_directed();
    add_item(OP_START, 16'h0000, 8'h5A, 8'h01, 16'h0000, 1'b1);   // zero source
    add_item(OP_START, 16'h1234, 8'h11, 8'h01, 16'h0000, 1'b1);   // wrong hw type
    add_item(OP_START, 16'h1234, 8'h5A, 8'h01, 16'h0000, 1'b0);   // failed send
    add_item(OP_TICK, 16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0);    // unarmed tick
    add_item(OP_DATA, 16'h1234, 8'h5A, 8'h01, 16'h0400, 1'b0);    // no owner yet
    add_item(OP_START, 16'h1234, 8'h5A, 8'h01, 16'h0000, 1'b1);   // claim
    add_item(OP_START, 16'h1234, 8'h5A, 8'h01, 16'h0000, 1'b1);   // already owner
    add_item(OP_START, 16'hBEEF, 8'h5A, 8'h01, 16'h0000, 1'b1);   // passive
    add_item(OP_DATA, 16'h1234, 8'h5A, 8'h01, 16'h03FF, 1'b0);    // below program area
    add_item(OP_DATA, 16'h1234, 8'h5A, 8'h02, 16'h0400, 1'b0);    // wrong version
    add_item(OP_DATA, 16'h1234, 8'h5A, 8'h01, 16'h0400, 1'b0);    // served
    repeat (3) add_item(OP_TICK, 16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0); // expiry
    add_item(OP_START, 16'h1234, 8'h5A, 8'h01, 16'h0000, 1'b1);
    add_item(OP_CLEAR, 16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0);   // countdown keeps going
    repeat (3) add_item(OP_TICK, 16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0);
    add_item(OP_TRIGGER, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
    add_item(3'd7, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);        // unused opcode
    add_item(OP_START, 16'hFFFF, 8'h5A, 8'h01, 16'h0000, 1'b1);   // claims "no node"
    add_item(OP_START, 16'h2222, 8'h5A, 8'h01, 16'h0000, 1'b1);
    add_item(OP_DATA, 16'h2222, 8'h5A, 8'h01, 16'h0480, 1'b0);    // end address: done
    add_item(OP_DATA, 16'hFFFF, 8'hFF, 8'hFF, PRGM_END + 16'd1, 1'b1);
  endtask

  // Mostly well-formed sessions with random content, plus noise
  task automatic add_random(input int count);
    int          n;
    int          pick;
    int          burst;
    logic [15:0] node;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        // start request
        burst = $urandom_range(0, 99);
        if (burst < 25) begin
          sess_node = 16'($urandom_range(1, 16'hFFFE));
          sess_addr = PRGM_START;
          node = sess_node;
        end else if (burst < 40) begin
          node = 16'($urandom_range(1, 16'hFFFF));
        end else begin
          node = sess_node;
        end
        add_item(OP_START, node,
                 ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_hw_type,
                 8'($urandom), 16'($urandom), ($urandom_range(0, 99) < 85));
        n++;
      end else if (pick < 60) begin
        // data request walking through the image
        if (sess_addr > cur_end_addr || sess_addr > PRGM_END) begin
          sess_addr = PRGM_START + 128 * $urandom_range(0, 3);
        end else if ($urandom_range(0, 7) == 0 && cur_end_addr >= PRGM_START + 256 &&
                     cur_end_addr <= PRGM_END) begin
          sess_addr = cur_end_addr - 128 * $urandom_range(0, 2);
        end
        add_item(OP_DATA,
                 ($urandom_range(0, 19) == 0) ? 16'($urandom) : sess_node,
                 ($urandom_range(0, 12) == 0) ? 8'($urandom) : cur_hw_type,
                 ($urandom_range(0, 12) == 0) ? 8'($urandom) : cur_version,
                 ($urandom_range(0, 14) == 0) ? 16'($urandom) : 16'(sess_addr),
                 1'($urandom));
        sess_addr = sess_addr + 128;
        n++;
      end else if (pick < 80) begin
        // ticks, now and then enough to expire the session
        burst = ($urandom_range(0, 9) == 0) ? int'(cur_expire) + 1 : $urandom_range(1, 4);
        repeat (burst) begin
          add_item(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                   1'($urandom));
          n++;
        end
      end else if (pick < 85) begin
        add_item(OP_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                 1'($urandom));
        n++;
      end else if (pick < 90) begin
        add_item(OP_TRIGGER, 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                 1'($urandom));
        n++;
      end else if (pick < 93) begin
        add_item(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 1'($urandom));
        n++;
      end else begin
        add_item(3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 1'($urandom));
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (request_q.size() != 0 || expected_replies.size() != 0 || in_ch.valid)
      @(negedge clk);
  endtask

  // Main sequence: reset, then six phases of config and traffic
  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.opcode           = '0;
    in_ch.src_address      = '0;
    in_ch.req_hw_type      = '0;
    in_ch.req_version      = '0;
    in_ch.req_data_address = '0;
    in_ch.send_ok          = 1'b0;
    out_ch.ready           = 1'b0;
    cur_hw_type            = RST_HW_TYPE;
    cur_version            = RST_VERSION;
    cur_end_addr           = RST_END_ADDR;
    cur_expire             = RST_EXPIRE;
    owner_node             = NO_NODE;
    timer_armed            = 1'b0;
    timer_left             = RST_EXPIRE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      repeat (3) @(negedge clk);
      case (phase)
        0: load_config(8'h5A, 8'h01, 16'h0480, 8'd3);
        1: load_config(8'h00, 8'h00, 16'h0000, 8'd1);
        2: load_config(8'hFF, 8'hFF, 16'hFFFF, 8'd255);
        3: load_config(8'($urandom), 8'($urandom), 16'($urandom_range(16'h400, 16'h6400)),
                       8'($urandom_range(1, 8)));
        4: load_config(8'h3C, 8'h80, PRGM_END, 8'd2);
        default: load_config(8'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom_range(1, 12)));
      endcase
      @(negedge clk);
      // receiver-heavy idling, then sender-heavy, then none
      case (phase / 2)
        0: begin send_idle_pct = 22; recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 0) add_directed();
      add_random(142);
    end

    wait_drained();
    repeat (5) @(negedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
